/* sv/ipdc_pkg.sv */
// ----------------------------------------------------------------------------
// ipdc_pkg: shared types and constants for the duotone colorizer
// Color mode codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package ipdc_pkg;

    typedef enum logic [1:0] {
        MODE_GRAY  = 2'd0,
        MODE_FORE  = 2'd1,
        MODE_BLEND = 2'd2
    } color_mode_t;

    typedef enum logic [1:0] {
        REG_DEPTH = 2'd0,
        REG_MODE  = 2'd1,
        REG_FORE  = 2'd2,
        REG_BACK  = 2'd3
    } reg_index_t;

    localparam int unsigned BYTE_BITS = 8;
    localparam int unsigned CHAN_BITS = 8;
    localparam int unsigned RGB_BITS  = 3 * CHAN_BITS;
    localparam int unsigned CNT_BITS  = 4;

    localparam logic [1:0]          DEPTH_RESET = 2'd3;
    localparam logic [RGB_BITS-1:0] FORE_RESET  = 24'h000000;
    localparam logic [RGB_BITS-1:0] BACK_RESET  = 24'hFFFFFF;

endpackage

`default_nettype wire

/* sv/ipdc_blend.sv */
// ----------------------------------------------------------------------------
// ipdc_blend: one color channel of the colorizer
// Turns an index scaled to 0..255 into a channel value for the selected mode.
// ----------------------------------------------------------------------------
`default_nettype none

module ipdc_blend (
    input  wire logic [ipdc_pkg::CHAN_BITS-1:0] fore_chan,
    input  wire logic [ipdc_pkg::CHAN_BITS-1:0] back_chan,
    input  wire logic [ipdc_pkg::CHAN_BITS-1:0] scale,
    input  wire ipdc_pkg::color_mode_t          mode,
    output logic      [ipdc_pkg::CHAN_BITS-1:0] chan
);
    import ipdc_pkg::*;

    logic signed [8:0]  diff;
    logic signed [17:0] prod;
    logic signed [17:0] base;
    logic signed [17:0] total;
    logic        [15:0] num;
    logic        [16:0] quot_sum;
    logic        [7:0]  blend;

    // The scale is index * 255 / max_index, which is always an integer, so
    // the gradient is round((fore * 255 + (back - fore) * scale) / 255).
    always_comb
    begin
        diff     = $signed({1'b0, back_chan}) - $signed({1'b0, fore_chan});
        prod     = 18'(diff * $signed({1'b0, scale}));
        base     = $signed({2'b00, fore_chan, 8'h00}) - $signed({10'd0, fore_chan});
        total    = base + prod + 18'sd127;
        num      = total[15:0];
        // Exact floor division by 255 for quotients up to 255.
        quot_sum = {1'b0, num} + 17'd1 + {9'd0, num[15:8]};
        blend    = quot_sum[15:8];
    end

    always_comb
    begin
        case (mode)
            MODE_BLEND: chan = blend;
            MODE_FORE:  chan = (scale == '0) ? fore_chan : scale;
            default:    chan = scale;
        endcase
    end

endmodule

`default_nettype wire

/* sv/indexed_pixel_duotone_colorize_core.sv */
// An accepted byte loads the unpack register; its first pixel is then registered at the output.
// A byte gives 8, 4, 2 or 1 pixels at 1, 2, 4 or 8 bits per index, one per cycle while not stalled.
// The unpack register gives one index per cycle unless stalled and takes the next byte with the last.
// Reset clears the configuration to its defaults and empties the unpack and output registers.
// ----------------------------------------------------------------------------
// indexed_pixel_duotone_colorize_core: packed index to RGB pixel colorizer
// Unpacks a byte of palette indices and colors each one by the selected mode.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_pixel_duotone_colorize_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [1:0]                          cfg_index,
    input  wire logic [ipdc_pkg::RGB_BITS-1:0]       cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [ipdc_pkg::BYTE_BITS-1:0]      data_byte,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic      [ipdc_pkg::CHAN_BITS-1:0]      red,
    output logic      [ipdc_pkg::CHAN_BITS-1:0]      green,
    output logic      [ipdc_pkg::CHAN_BITS-1:0]      blue,
    output logic                                     last_in_byte
);
    import ipdc_pkg::*;

    logic [1:0]          depth_reg;
    color_mode_t         mode_reg;
    logic [RGB_BITS-1:0] fore_reg;
    logic [RGB_BITS-1:0] back_reg;

    logic [BYTE_BITS-1:0] shift_reg;
    logic [BYTE_BITS-1:0] shift_next;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [CNT_BITS-1:0]  cnt_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CHAN_BITS-1:0] red_reg;
    logic [CHAN_BITS-1:0] green_reg;
    logic [CHAN_BITS-1:0] blue_reg;
    logic                 last_reg;

    logic                 busy;
    logic                 advance;
    logic                 take;
    logic                 is_last;
    logic [BYTE_BITS-1:0] scale;
    logic [CHAN_BITS-1:0] red_pix;
    logic [CHAN_BITS-1:0] green_pix;
    logic [CHAN_BITS-1:0] blue_pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= DEPTH_RESET;
            mode_reg  <= MODE_GRAY;
            fore_reg  <= FORE_RESET;
            back_reg  <= BACK_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_DEPTH: depth_reg <= cfg_data[1:0];
                REG_MODE:  mode_reg  <= color_mode_t'(cfg_data[1:0]);
                REG_FORE:  fore_reg  <= cfg_data;
                REG_BACK:  back_reg  <= cfg_data;
                default:   depth_reg <= depth_reg;
            endcase
        end
    end

    assign busy     = (cnt_reg != '0);
    assign is_last  = (cnt_reg == CNT_BITS'(1));
    assign advance  = busy && (!out_valid_reg || out_ready);
    assign in_ready = !busy || (is_last && advance);
    assign take     = in_valid && in_ready;

    // The top index, replicated to fill a byte, equals index * 255 / max_index.
    always_comb
    begin
        case (depth_reg)
            2'd0:    scale = {8{shift_reg[7]}};
            2'd1:    scale = {4{shift_reg[7:6]}};
            2'd2:    scale = {2{shift_reg[7:4]}};
            default: scale = shift_reg;
        endcase
    end

    always_comb
    begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        if (take)
        begin
            shift_next = data_byte;
            cnt_next   = CNT_BITS'(BYTE_BITS) >> depth_reg;
        end
        else if (advance)
        begin
            shift_next = shift_reg << (4'd1 << depth_reg);
            cnt_next   = cnt_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    ipdc_blend u_red (
        .fore_chan (fore_reg[23:16]),
        .back_chan (back_reg[23:16]),
        .scale     (scale),
        .mode      (mode_reg),
        .chan      (red_pix)
    );

    ipdc_blend u_green (
        .fore_chan (fore_reg[15:8]),
        .back_chan (back_reg[15:8]),
        .scale     (scale),
        .mode      (mode_reg),
        .chan      (green_pix)
    );

    ipdc_blend u_blue (
        .fore_chan (fore_reg[7:0]),
        .back_chan (back_reg[7:0]),
        .scale     (scale),
        .mode      (mode_reg),
        .chan      (blue_pix)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            red_reg   <= red_pix;
            green_reg <= green_pix;
            blue_reg  <= blue_pix;
            last_reg  <= is_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign last_in_byte = last_reg;

`ifndef SYNTHESIS
    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (cnt_reg != '0))
        else $error("accepted request did not load the unpack register");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(BYTE_BITS))
        else $error("pixel count exceeds the byte width");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_last && !take) |=> (cnt_reg == '0))
        else $error("unpack register not empty after its last pixel");

    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && mode_reg == MODE_GRAY) |->
        (red_reg == green_reg && green_reg == blue_reg))
        else $error("gray ramp pixel has unequal channels");

    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_valid_reg && last_reg == $past(is_last)))
        else $error("output register missed a pixel");
`endif

endmodule

`default_nettype wire
